// File: hw/rtl/ansc_pkg.sv
// Shared types and constants for the Annex B start code splitter.
`timescale 1ns / 1ps

package ansc_pkg;

    // Byte that ends a start code after a run of zero bytes.
    localparam logic [7:0] START_CODE_END = 8'h01;

    // Zero run codes: the run counter holds at its top value.
    localparam logic [1:0] ZERO_RUN_MAX   = 2'd3;
    localparam logic [1:0] ZERO_RUN_SHORT = 2'd2;

    // Stream bus widths.
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 64;

    // Which results one queue entry carries.
    typedef struct packed {
        logic has_close;  // unit closed by a new start code
        logic has_flush;  // unit closed by end of stream
    } ansc_flags_t;

endpackage

// File: hw/rtl/ansc_front.sv
// Front end: tracks zero runs and byte position, finds start codes and queues unit bounds.
`timescale 1ns / 1ps

module ansc_front #(
    parameter int POSITION_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ansc_pkg::IN_DATA_W-1:0]       s_tdata,   // [7:0] byte_value
    input  logic                                 s_tlast,   // end_of_stream
    input  logic                                 q_ready,
    output logic                                 q_push,
    output ansc_pkg::ansc_flags_t                q_flags,
    output logic [POSITION_BITS-1:0]             q_close_start,
    output logic [POSITION_BITS-1:0]             q_close_end,
    output logic [POSITION_BITS-1:0]             q_flush_start,
    output logic [POSITION_BITS:0]               q_flush_end
);
    import ansc_pkg::*;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [1:0]               zrun_reg, zrun_next;
    logic                     open_reg, open_next;

    logic                     accept;
    logic                     is_zero;
    logic                     sc_hit;
    logic [1:0]               back_cnt;
    logic [POSITION_BITS-1:0] sc_pos;
    logic [POSITION_BITS-1:0] new_start;
    logic                     new_open;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && s_tready;

    // Start code detection and the position where it begins.
    always_comb begin
        is_zero  = (s_tdata == '0);
        sc_hit   = (s_tdata == START_CODE_END) && (zrun_reg >= ZERO_RUN_SHORT);
        back_cnt = (zrun_reg == ZERO_RUN_MAX) ? 2'd3 : 2'd2;
        if (pos_reg >= POSITION_BITS'(back_cnt)) begin
            sc_pos = pos_reg - POSITION_BITS'(back_cnt);
        end else begin
            sc_pos = '0;
        end
        new_start = sc_hit ? sc_pos : start_reg;
        new_open  = open_reg || sc_hit;
    end

    // Queue entry: up to two closed units for this byte.
    always_comb begin
        q_flags.has_close = sc_hit && open_reg;
        q_flags.has_flush = s_tlast && new_open;
        q_close_start     = start_reg;
        q_close_end       = sc_pos;
        q_flush_start     = new_start;
        q_flush_end       = {1'b0, pos_reg} + {{POSITION_BITS{1'b0}}, 1'b1};
        q_push            = accept && (q_flags.has_close || q_flags.has_flush);
    end

    // Scanner state update; end of stream returns to the reset state.
    always_comb begin
        pos_next   = pos_reg;
        start_next = start_reg;
        zrun_next  = zrun_reg;
        open_next  = open_reg;
        if (accept) begin
            if (s_tlast) begin
                pos_next   = '0;
                start_next = '0;
                zrun_next  = '0;
                open_next  = 1'b0;
            end else begin
                pos_next   = (pos_reg != '1) ? pos_reg + 1'b1 : pos_reg;
                start_next = new_start;
                open_next  = new_open;
                if (is_zero) begin
                    zrun_next = (zrun_reg != ZERO_RUN_MAX) ? zrun_reg + 2'd1 : zrun_reg;
                end else begin
                    zrun_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            start_reg <= '0;
            zrun_reg  <= '0;
            open_reg  <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            zrun_reg  <= zrun_next;
            open_reg  <= open_next;
        end
    end

endmodule

// File: hw/rtl/ansc_queue.sv
// Two-entry queue between the front end and the result stage.
`timescale 1ns / 1ps

module ansc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             ready,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             valid
);
    import ansc_pkg::*;

    logic [WIDTH-1:0] mem [2];
    logic [1:0]       count_reg, count_next;
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;

    assign ready     = (count_reg != 2'd2);
    assign valid     = (count_reg != 2'd0);
    assign head_data = mem[rd_ptr_reg];

    // Pointer and fill count bookkeeping.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/ansc_back.sv
// Result stage: turns queued unit bounds into offset and length transfers.
`timescale 1ns / 1ps

module ansc_back #(
    parameter int POSITION_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    output logic                                 q_pop,
    input  ansc_pkg::ansc_flags_t                q_flags,
    input  logic [POSITION_BITS-1:0]             q_close_start,
    input  logic [POSITION_BITS-1:0]             q_close_end,
    input  logic [POSITION_BITS-1:0]             q_flush_start,
    input  logic [POSITION_BITS:0]               q_flush_end,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ansc_pkg::OUT_DATA_W-1:0]      m_tdata,   // [31:0] nal_offset, [63:32] nal_length
    output logic [0:0]                           m_tuser,   // [0] from_flush
    output logic                                 m_tlast    // last_of_run
);
    import ansc_pkg::*;

    localparam int XW = (POSITION_BITS + 1 > 32) ? POSITION_BITS + 1 : 32;

    logic                  valid_reg, valid_next;
    logic                  close_done_reg, close_done_next;
    logic [OUT_DATA_W-1:0] data_reg, data_next;
    logic                  flush_reg, flush_next;
    logic                  last_reg, last_next;

    logic                  load;
    logic                  emit_close;
    logic [XW-1:0]         start_x;
    logic [XW-1:0]         end_x;
    logic [XW-1:0]         len_x;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = flush_reg;
    assign m_tlast  = last_reg;

    assign load       = !valid_reg || m_tready;
    assign emit_close = q_flags.has_close && !close_done_reg;

    // Pick the next result of the head entry and work out its length.
    always_comb begin
        if (emit_close) begin
            start_x = XW'(q_close_start);
            end_x   = XW'(q_close_end);
        end else begin
            start_x = XW'(q_flush_start);
            end_x   = XW'(q_flush_end);
        end
        len_x = (end_x >= start_x) ? end_x - start_x : '0;
    end

    // Output register and per-entry progress.
    always_comb begin
        valid_next      = valid_reg;
        close_done_next = close_done_reg;
        data_next       = data_reg;
        flush_next      = flush_reg;
        last_next       = last_reg;
        q_pop           = 1'b0;
        if (load) begin
            valid_next = q_valid;
            if (q_valid) begin
                data_next  = {len_x[31:0], start_x[31:0]};
                flush_next = !emit_close;
                if (emit_close && q_flags.has_flush) begin
                    last_next       = 1'b0;
                    close_done_next = 1'b1;
                end else begin
                    last_next       = 1'b1;
                    close_done_next = 1'b0;
                    q_pop           = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            close_done_reg <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            close_done_reg <= close_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        flush_reg <= flush_next;
        last_reg  <= last_next;
    end

endmodule

// File: hw/rtl/annexb_nal_start_code_splitter_core.sv
// Top level of the Annex B start code splitter: front end, queue and result stage.
`timescale 1ns / 1ps

// The block takes an H.264 Annex B byte stream one byte per transfer and reports
// each unit found between start codes (00 00 01 or 00 00 00 01) as one output
// transfer carrying its stream byte offset and its length, start code included.
// Bytes before the first start code are dropped. A byte with s_tlast set ends
// the stream: the open unit is flushed (m_tuser set) and the position restarts
// at zero. Positions saturate at 2^POSITION_BITS - 1; offset and length carry
// the low 32 bits. A new byte is taken every clock cycle while the two-entry
// queue between the scanner and the result stage has room; the entry for the byte
// that closes a unit is written into the queue and then loaded into the output
// register. The result stage issues one result per cycle while m_tready is high,
// so an end-of-stream byte that closes two units gives two output transfers, and
// the sustained input rate is one byte per cycle as long as m_tready stays high.
module annexb_nal_start_code_splitter_core #(
    parameter int POSITION_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ansc_pkg::IN_DATA_W-1:0]       s_tdata,   // [7:0] byte_value
    input  logic                                 s_tlast,   // end_of_stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ansc_pkg::OUT_DATA_W-1:0]      m_tdata,   // [31:0] nal_offset, [63:32] nal_length
    output logic [0:0]                           m_tuser,   // [0] from_flush
    output logic                                 m_tlast    // last_of_run
);
    import ansc_pkg::*;

    localparam int QW = 2 + 4 * POSITION_BITS + 1;

    logic                     q_push, q_ready, q_pop, q_valid;
    ansc_flags_t              f_flags, b_flags;
    logic [POSITION_BITS-1:0] f_close_start, f_close_end, f_flush_start;
    logic [POSITION_BITS:0]   f_flush_end;
    logic [POSITION_BITS-1:0] b_close_start, b_close_end, b_flush_start;
    logic [POSITION_BITS:0]   b_flush_end;
    logic [QW-1:0]            q_in, q_out;

    ansc_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_flags       (f_flags),
        .q_close_start (f_close_start),
        .q_close_end   (f_close_end),
        .q_flush_start (f_flush_start),
        .q_flush_end   (f_flush_end)
    );

    // Pack and unpack queue entries.
    assign q_in = {f_flags, f_close_start, f_close_end, f_flush_start, f_flush_end};
    assign {b_flags, b_close_start, b_close_end, b_flush_start, b_flush_end} = q_out;

    ansc_queue #(
        .WIDTH(QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .ready     (q_ready),
        .pop       (q_pop),
        .head_data (q_out),
        .valid     (q_valid)
    );

    ansc_back #(
        .POSITION_BITS(POSITION_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_flags       (b_flags),
        .q_close_start (b_close_start),
        .q_close_end   (b_close_end),
        .q_flush_start (b_flush_start),
        .q_flush_end   (b_flush_end),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

    // A flushed unit is always the last result of its byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("flushed unit not marked last of run");

    // The result stage never takes an entry from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // Every queued entry carries at least one result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> (b_flags.has_close || b_flags.has_flush))
        else $error("queue entry without a result");

    // No result is presented in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the Annex B start code splitter core.
`timescale 1ns / 1ps

module testbench;

    import ansc_pkg::*;

    // Position counter width for the block under test.
    localparam int          POS_BITS    = 16;
    localparam logic [63:0] POS_LIMIT   = (64'd1 << POS_BITS) - 64'd1;
    localparam int          STALL_LIMIT = 2000;
    localparam int          RANDOM_ITEMS = 500;
    localparam int          IDLE_PERCENT = 23;

    // One reported unit as it travels on the result channel.
    typedef struct {
        logic [31:0] nal_offset;
        logic [31:0] nal_length;
        logic        from_flush;
        logic        last_of_run;
    } nal_unit_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // [7:0] byte_value
    logic                  s_tlast;   // end_of_stream
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // [31:0] nal_offset, [63:32] nal_length
    logic [0:0]            m_tuser;   // [0] from_flush
    logic                  m_tlast;   // last_of_run

    // Scanner state of the prediction.
    logic [63:0] scan_pos;
    logic [1:0]  zero_count;
    logic        unit_is_open;
    logic [63:0] unit_begin;

    nal_unit_t   pending_units[$];
    int          error_count;
    int          stall_count;
    int          hold_cycles;
    bit          idle_enabled;

    annexb_nal_start_code_splitter_core #(
        .POSITION_BITS(POS_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever begin
            #6 aclk = ~aclk;
        end
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Work out the units closed by one accepted byte and queue them in order.
    function automatic void predict_units(input logic [7:0] value, input logic eos);
        nal_unit_t   found[2];
        int          n;
        int          i;
        logic [63:0] back;
        logic [63:0] code_pos;
        logic [63:0] span;
        n = 0;
        if (value == 8'h00) begin
            if (zero_count != ZERO_RUN_MAX) begin
                zero_count = zero_count + 2'd1;
            end
        end else begin
            if (value == START_CODE_END && zero_count >= ZERO_RUN_SHORT) begin
                back = (zero_count == ZERO_RUN_MAX) ? 64'd3 : 64'd2;
                code_pos = (scan_pos >= back) ? scan_pos - back : 64'd0;
                if (unit_is_open) begin
                    span = (code_pos >= unit_begin) ? code_pos - unit_begin : 64'd0;
                    found[n] = '{unit_begin[31:0], span[31:0], 1'b0, 1'b0};
                    n++;
                end
                unit_begin = code_pos;
                unit_is_open = 1'b1;
            end
            zero_count = 2'd0;
        end
        if (eos) begin
            // The flushed unit runs up to and including this byte.
            if (unit_is_open) begin
                span = (scan_pos + 64'd1 >= unit_begin) ? scan_pos + 64'd1 - unit_begin
                                                        : 64'd0;
                found[n] = '{unit_begin[31:0], span[31:0], 1'b1, 1'b0};
                n++;
            end
            scan_pos = 64'd0;
            zero_count = 2'd0;
            unit_is_open = 1'b0;
            unit_begin = 64'd0;
        end else if (scan_pos < POS_LIMIT) begin
            scan_pos = scan_pos + 64'd1;
        end
        for (i = 0; i < n; i++) begin
            found[i].last_of_run = (i == n - 1);
            pending_units.push_back(found[i]);
        end
    endfunction

    // Offer one byte, with random gaps, until the block takes the transfer.
    task automatic send_byte(input logic [7:0] value, input logic eos);
        @(negedge aclk);
        while (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predict_units(value, eos);
    endtask

    // Drop valid and wait until every queued unit has been checked.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_units.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Leading bytes, both start code forms, a lone 00 01 and extreme byte values.
    task automatic test_stream_basics();
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(START_CODE_END, 1'b0);
        send_byte(8'h67, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(START_CODE_END, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(START_CODE_END, 1'b0);
        // A zero run longer than three still starts the code three bytes back.
        repeat (4) send_byte(8'h00, 1'b0);
        send_byte(START_CODE_END, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_for_drain();
    endtask

    // End of stream with no unit open, and a start code on the last byte.
    task automatic test_flush_cases();
        send_byte(8'h7F, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(START_CODE_END, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(START_CODE_END, 1'b1);
        wait_for_drain();
    endtask

    // Mostly well-formed units with random payload, mixed with noise and stream ends.
    task automatic test_random_streams();
        int  sent;
        int  zeros;
        int  plen;
        bit  eos_now;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // Leave a stretch in the middle with no idling on either side.
            idle_enabled = !(sent >= 200 && sent < 320);
            if ($urandom_range(99) < 75) begin
                zeros = ($urandom_range(3) == 0) ? $urandom_range(6, 3) : $urandom_range(3, 2);
                repeat (zeros) send_byte(8'h00, 1'b0);
                eos_now = ($urandom_range(19) == 0);
                send_byte(START_CODE_END, eos_now);
                sent += zeros + 1;
                if (!eos_now) begin
                    plen = $urandom_range(10);
                    repeat (plen) begin
                        send_byte(($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255)),
                                  1'b0);
                    end
                    sent += plen;
                end
            end else begin
                plen = $urandom_range(6, 1);
                repeat (plen) begin
                    case ($urandom_range(3))
                        0:       send_byte(8'h00, 1'b0);
                        1:       send_byte(START_CODE_END, 1'b0);
                        default: send_byte(8'($urandom_range(255)), 1'b0);
                    endcase
                end
                sent += plen;
            end
            if ($urandom_range(99) < 8) begin
                send_byte(8'($urandom_range(255)), 1'b1);
                sent++;
            end
        end
        idle_enabled = 1'b1;
        wait_for_drain();
    endtask

    // The receiver holds off while short units keep coming, so the input stalls.
    task automatic test_receiver_backpressure();
        hold_cycles = 300;
        repeat (10) begin
            send_byte(8'h00, 1'b0);
            send_byte(8'h00, 1'b0);
            send_byte(START_CODE_END, 1'b0);
            send_byte(8'($urandom_range(255, 2)), 1'b0);
        end
        send_byte(8'h5A, 1'b1);
        wait_for_drain();
    endtask

    // Receiver: long hold-off when asked, random stalls otherwise.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (idle_enabled) begin
                m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare every result transfer with the oldest predicted unit.
    always @(posedge aclk) begin : check_results
        nal_unit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_units.size() == 0) begin
                report_mismatch($sformatf("unexpected unit offset %0d length %0d",
                                          m_tdata[31:0], m_tdata[63:32]));
            end else begin
                want = pending_units.pop_front();
                if (m_tdata[31:0] !== want.nal_offset) begin
                    report_mismatch($sformatf("nal_offset got %0d expected %0d",
                                              m_tdata[31:0], want.nal_offset));
                end
                if (m_tdata[63:32] !== want.nal_length) begin
                    report_mismatch($sformatf("nal_length got %0d expected %0d",
                                              m_tdata[63:32], want.nal_length));
                end
                if (m_tuser[0] !== want.from_flush) begin
                    report_mismatch($sformatf("from_flush got %b expected %b",
                                              m_tuser[0], want.from_flush));
                end
                if (m_tlast !== want.last_of_run) begin
                    report_mismatch($sformatf("last_of_run got %b expected %b",
                                              m_tlast, want.last_of_run));
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // Reset, then the tests in turn, then the verdict.
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        error_count  = 0;
        stall_count  = 0;
        hold_cycles  = 0;
        idle_enabled = 1'b1;
        scan_pos     = 64'd0;
        zero_count   = 2'd0;
        unit_is_open = 1'b0;
        unit_begin   = 64'd0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_stream_basics();
        test_flush_cases();
        test_random_streams();
        test_receiver_backpressure();

        repeat (8) @(posedge aclk);
        while (pending_units.size() != 0) begin
            report_mismatch($sformatf("missing unit offset %0d length %0d",
                                      pending_units[0].nal_offset,
                                      pending_units[0].nal_length));
            void'(pending_units.pop_front());
        end
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
